>>> src/dart_pkg.sv
//------------------------------------------------------------------------------
// Device address range table package
// Sizes, word formats, request and status codes and sequencer states shared by
// the range table logic.
//------------------------------------------------------------------------------
`default_nettype none

package dart_pkg;

	// Table geometry and field widths.
	localparam int ENTRIES     = 64;
	localparam int ADDR_BITS   = 48;
	localparam int DEVICE_BITS = 8;
	localparam int SIZE_BITS   = ADDR_BITS + 1;
	localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// One past the highest address, at the width of begin plus size.
	localparam logic [ADDR_BITS+1:0] ADDR_SPAN = {2'b01, {ADDR_BITS{1'b0}}};

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_CHECK  = 2'd2
	} req_code_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_OVERLAP   = 3'd1,
		STAT_NOT_FOUND = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_BAD_SIZE  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_SCAN,
		S_LAST,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]             req_type;
		logic [DEVICE_BITS-1:0] device_id;
		logic [ADDR_BITS-1:0]   address;
		logic [SIZE_BITS-1:0]   region_size;
	} req_word_t;

	typedef struct packed {
		logic [2:0]           status;
		logic                 found;
		logic [ADDR_BITS-1:0] found_begin;
		logic [ADDR_BITS-1:0] found_end;
	} rsp_word_t;

	// One stored region.
	typedef struct packed {
		logic [DEVICE_BITS-1:0] dev;
		logic [ADDR_BITS-1:0]   first_addr;
		logic [ADDR_BITS-1:0]   last_addr;
	} entry_t;

endpackage

`default_nettype wire

>>> src/device_address_range_table_top.sv
// A word accepted in S_IDLE passes S_PREP, S_SCAN, S_LAST and S_FINISH; an add
// with a bad size or an unused request code goes from S_PREP to S_FINISH. No new
// word is taken until its result is written. The single compare unit walks the
// 64 table entries through the one read port of the region memory. Reset clears
// all valid bits, the sequencer and the result valid flag at once; the region
// memory itself is not cleared and no clearing pass is needed.
//------------------------------------------------------------------------------
// Device address range table
// Keeps registered memory regions per device, rejects overlapping adds, and
// finds, checks or removes the region that holds a probe address.
//------------------------------------------------------------------------------
`default_nettype none

module device_address_range_table_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output      logic                req_stall,
	input  wire dart_pkg::req_word_t req_word,
	output      logic                rsp_valid,
	input  wire logic                rsp_stall,
	output      dart_pkg::rsp_word_t rsp_word
);

	// Sequencer state.
	dart_pkg::state_t state_q;
	dart_pkg::state_t state_d;

	// The request being served.
	dart_pkg::req_code_t                req_code_q;
	logic [dart_pkg::DEVICE_BITS-1:0]   dev_q;
	logic [dart_pkg::ADDR_BITS-1:0]     addr_q;
	logic [dart_pkg::ADDR_BITS+1:0]     sum_q;
	logic                               size_zero_q;
	logic [dart_pkg::ADDR_BITS-1:0]     last_q;
	logic                               bad_q;

	// Region memory, its read port and the valid bits.
	dart_pkg::entry_t                   mem_q [dart_pkg::ENTRIES];
	logic [dart_pkg::ENTRIES-1:0]       valid_q;
	logic [dart_pkg::IDX_W-1:0]         iss_q;
	logic                               cmp_v_s1;
	logic [dart_pkg::IDX_W-1:0]         idx_s1;
	logic                               vld_s1;
	dart_pkg::entry_t                   rd_s1;

	// Scan results: first matching region and first free entry.
	logic                               hit_q;
	logic [dart_pkg::IDX_W-1:0]         hit_idx_q;
	logic [dart_pkg::ADDR_BITS-1:0]     hit_first_q;
	logic [dart_pkg::ADDR_BITS-1:0]     hit_last_q;
	logic                               free_q;
	logic [dart_pkg::IDX_W-1:0]         free_idx_q;

	// Result register.
	logic                               out_valid_q;
	dart_pkg::rsp_word_t                out_q;

	// Control decoded from the state.
	logic                               accept;
	logic                               issue;
	logic                               out_free;
	logic                               finish;
	logic                               bad_now;
	logic                               is_add;
	logic [dart_pkg::ADDR_BITS-1:0]     probe_hi;
	logic                               match;
	logic                               do_store;
	logic                               do_remove;
	dart_pkg::rsp_word_t                result;

	// A size is bad when it is zero or when begin+size-1 runs past the top
	// address, that is when begin+size exceeds the address span.
	assign bad_now = size_zero_q || (sum_q > dart_pkg::ADDR_SPAN);
	assign is_add  = (req_code_q == dart_pkg::REQ_ADD);

	// The compare unit tests whether [first, last] of an entry meets the
	// probe range. For an add that range is the new region; for delete and
	// check it is the single probe address, which turns the test into
	// containment.
	assign probe_hi = is_add ? last_q : addr_q;
	assign match    = cmp_v_s1 && vld_s1 && (rd_s1.dev == dev_q) &&
		(rd_s1.first_addr <= probe_hi) && (rd_s1.last_addr >= addr_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			dart_pkg::S_IDLE: begin
				if (accept) begin
					state_d = dart_pkg::S_PREP;
				end
			end
			dart_pkg::S_PREP: begin
				if ((is_add && bad_now) ||
					((req_code_q != dart_pkg::REQ_ADD) &&
					 (req_code_q != dart_pkg::REQ_DELETE) &&
					 (req_code_q != dart_pkg::REQ_CHECK))) begin
					state_d = dart_pkg::S_FINISH;
				end else begin
					state_d = dart_pkg::S_SCAN;
				end
			end
			dart_pkg::S_SCAN: begin
				if (iss_q == dart_pkg::IDX_W'(dart_pkg::ENTRIES - 1)) begin
					state_d = dart_pkg::S_LAST;
				end
			end
			dart_pkg::S_LAST: begin
				state_d = dart_pkg::S_FINISH;
			end
			dart_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = dart_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dart_pkg::S_IDLE;
			end
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		req_stall = (state_q != dart_pkg::S_IDLE);
		accept    = req_valid && (state_q == dart_pkg::S_IDLE);
		issue     = (state_q == dart_pkg::S_SCAN);
		out_free  = !out_valid_q || !rsp_stall;
		finish    = (state_q == dart_pkg::S_FINISH) && out_free;
	end

	// Decision on the finished scan; for an add the checks take priority in the order
	// size, then a full table, then an overlap.
	always_comb begin
		result    = '0;
		do_store  = 1'b0;
		do_remove = 1'b0;
		result.status = dart_pkg::STAT_NOT_FOUND;
		case (req_code_q)
			dart_pkg::REQ_ADD: begin
				if (bad_q) begin
					result.status = dart_pkg::STAT_BAD_SIZE;
				end else if (!free_q) begin
					result.status = dart_pkg::STAT_FULL;
				end else if (hit_q) begin
					result.status      = dart_pkg::STAT_OVERLAP;
					result.found_begin = hit_first_q;
					result.found_end   = hit_last_q;
				end else begin
					result.status = dart_pkg::STAT_OK;
					do_store      = 1'b1;
				end
			end
			dart_pkg::REQ_DELETE, dart_pkg::REQ_CHECK: begin
				if (hit_q) begin
					result.status      = dart_pkg::STAT_OK;
					result.found       = 1'b1;
					result.found_begin = hit_first_q;
					result.found_end   = hit_last_q;
					do_remove          = (req_code_q == dart_pkg::REQ_DELETE);
				end
			end
			default: begin
				result.status = dart_pkg::STAT_NOT_FOUND;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dart_pkg::S_IDLE;
			cmp_v_s1    <= 1'b0;
			valid_q     <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cmp_v_s1 <= issue;
			if (accept) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (match) begin
					hit_q <= 1'b1;
				end
				if (cmp_v_s1 && !vld_s1) begin
					free_q <= 1'b1;
				end
			end
			if (finish && do_store) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (finish && do_remove) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request, scan and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_code_q  <= dart_pkg::req_code_t'(req_word.req_type);
			dev_q       <= req_word.device_id;
			addr_q      <= req_word.address;
			sum_q       <= {2'b00, req_word.address} + {1'b0, req_word.region_size};
			size_zero_q <= (req_word.region_size == '0);
		end
		if (state_q == dart_pkg::S_PREP) begin
			last_q <= sum_q[dart_pkg::ADDR_BITS-1:0] - dart_pkg::ADDR_BITS'(1);
			bad_q  <= bad_now;
			iss_q  <= '0;
		end else if (issue) begin
			iss_q <= iss_q + dart_pkg::IDX_W'(1);
		end
		idx_s1 <= iss_q;
		vld_s1 <= valid_q[iss_q];
		if (match && !hit_q) begin
			hit_idx_q   <= idx_s1;
			hit_first_q <= rd_s1.first_addr;
			hit_last_q  <= rd_s1.last_addr;
		end
		if (cmp_v_s1 && !vld_s1 && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (finish) begin
			out_q <= result;
		end
	end

	// Region memory: one write port for a stored add, one registered read port
	// driven by the scan counter.
	always_ff @(posedge clk) begin
		if (finish && do_store) begin
			mem_q[free_idx_q] <= '{dev: dev_q, first_addr: addr_q, last_addr: last_q};
		end
		rd_s1 <= mem_q[iss_q];
	end

	assign rsp_valid = out_valid_q;
	assign rsp_word  = out_q;

endmodule

`default_nettype wire
